[src/gbn_pkg.sv]
// Go-Back-N sender window: shared types and constants.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package gbn_pkg;

    localparam int SEG_W      = 16;
    localparam int XFER_W     = 24;
    localparam int WIN_W      = 6;
    localparam int ACK_W      = 32;
    localparam int OP_W       = 2;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SEGMENT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSFER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 2'd2;

    localparam logic [SEG_W-1:0]  SEG_RESET  = 16'd1024;
    localparam logic [XFER_W-1:0] XFER_RESET = 24'd0;
    localparam logic [WIN_W-1:0]  WIN_RESET  = 6'd8;

    // Input operation codes
    localparam logic [OP_W-1:0] OP_START   = 2'd0;
    localparam logic [OP_W-1:0] OP_ACK     = 2'd1;
    localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Serial divider: one quotient bit per cycle
    localparam int DIV_CNT_W = $clog2(XFER_W);

    typedef enum logic [1:0] {
        CMD_START   = 2'd0,
        CMD_ACK     = 2'd1,
        CMD_TIMEOUT = 2'd2,
        CMD_NOP     = 2'd3
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic              beyond;   // ack offset at or past the end of the object
        logic [XFER_W-1:0] ack;
    } t_cmd;

    typedef struct packed {
        logic [SEG_W-1:0]  seg_bytes;
        logic [XFER_W-1:0] xfer_bytes;
        logic [WIN_W-1:0]  win_segs;
    } t_cfg;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [ACK_W-1:0] ack_offset;
    } t_in;

    typedef struct packed {
        logic              seg_valid;
        logic [XFER_W-1:0] seg_offset;
        logic [SEG_W-1:0]  seg_length;
        logic              burst_last;
        logic              all_acked;
    } t_out;

    typedef struct packed {
        logic              done;
        logic              rem_nz;
        logic [XFER_W-1:0] quot;
    } t_div_rsp;

endpackage

`default_nettype wire

[src/go_back_n_sender_window.sv]
// Go-Back-N sender window: top level, configuration registers and wiring.
// Depends on gbn_pkg, gbn_front, gbn_fifo and gbn_back.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes one event per
//   beat: start, acknowledgement (with byte offset) or retransmission timeout.
//   Output channel (o_out_valid / i_out_stall / o_out_data) gives the burst an
//   event causes: one beat per released segment (offset, length), the final
//   one flagged burst_last, or a single empty beat when nothing is released.
//   Configuration (i_cfg_we / i_cfg_idx / i_cfg_data) writes segment size,
//   object size and window; write it only while the block is idle.
// Sequence: each event is dequeued, then a serial division gives the segment
//   count, a second serial division runs for an acknowledgement below the end
//   of the object, then each released segment takes an offset multiply, then
//   the output register, which waits while the output is stalled. A two-entry
//   queue keeps accepting events while the back end works, and o_in_stall
//   rises only when that queue is full.
// Reset: synchronous, active low; registers return to 1024 / 0 / 8 and both
//   window pointers to segment zero. A stalled output beat holds its value.
`timescale 1ns / 1ps
`default_nettype none

module go_back_n_sender_window #(
    parameter int MAX_WINDOW  = 32,
    parameter int OFFSET_BITS = 24
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [gbn_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [gbn_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  gbn_pkg::t_in                          i_in_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output gbn_pkg::t_out                         o_out_data
);

    logic [gbn_pkg::SEG_W-1:0]   r_seg_bytes;
    logic [gbn_pkg::XFER_W-1:0]  r_xfer_bytes;
    logic [gbn_pkg::WIN_W-1:0]   r_win_segs;
    gbn_pkg::t_cfg               cfg;

    logic                        q_push, q_full, q_pop, q_empty;
    gbn_pkg::t_cmd               q_in, q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_bytes  <= gbn_pkg::SEG_RESET;
            r_xfer_bytes <= gbn_pkg::XFER_RESET;
            r_win_segs   <= gbn_pkg::WIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gbn_pkg::REG_SEGMENT:  r_seg_bytes  <= i_cfg_data[gbn_pkg::SEG_W-1:0];
                gbn_pkg::REG_TRANSFER: r_xfer_bytes <= i_cfg_data[gbn_pkg::XFER_W-1:0];
                gbn_pkg::REG_WINDOW:   r_win_segs   <= i_cfg_data[gbn_pkg::WIN_W-1:0];
                default: begin
                    // no register at this index: drop the write
                end
            endcase
        end
    end

    assign cfg.seg_bytes  = r_seg_bytes;
    assign cfg.xfer_bytes = r_xfer_bytes;
    assign cfg.win_segs   = r_win_segs;

    gbn_front u_front (
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_xfer_bytes (r_xfer_bytes),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_cmd      (q_in)
    );

    gbn_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    gbn_back #(
        .MAX_WINDOW  (MAX_WINDOW),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .i_q_cmd     (q_out),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

[src/gbn_div.sv]
// Go-Back-N sender window: restoring serial divider, one quotient bit a cycle.
// Depends on gbn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbn_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [gbn_pkg::XFER_W-1:0]  i_num,
    input  wire logic [gbn_pkg::SEG_W-1:0]   i_den,
    output gbn_pkg::t_div_rsp                o_rsp
);

    logic                             r_busy, n_busy;
    logic                             r_done, n_done;
    logic [gbn_pkg::DIV_CNT_W-1:0]    r_cnt, n_cnt;
    logic [gbn_pkg::XFER_W-1:0]       r_num, n_num;
    logic [gbn_pkg::SEG_W-1:0]        r_rem, n_rem;
    logic [gbn_pkg::SEG_W-1:0]        r_den, n_den;
    logic [gbn_pkg::SEG_W:0]          rem_sh;
    logic                             fits;

    assign rem_sh = {r_rem, r_num[gbn_pkg::XFER_W-1]};
    assign fits   = rem_sh >= {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_num  = i_num;
            n_rem  = '0;
            n_den  = i_den;
        end else if (r_busy) begin
            n_num = {r_num[gbn_pkg::XFER_W-2:0], fits};
            n_rem = fits ? gbn_pkg::SEG_W'(rem_sh - {1'b0, r_den})
                         : rem_sh[gbn_pkg::SEG_W-1:0];
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == gbn_pkg::DIV_CNT_W'(gbn_pkg::XFER_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.rem_nz = |r_rem;
    assign o_rsp.quot   = r_num;

endmodule

`default_nettype wire

[src/gbn_fifo.sv]
// Go-Back-N sender window: short command queue between front and back.
// Depends on gbn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbn_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  gbn_pkg::t_cmd      i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output gbn_pkg::t_cmd      o_data
);

    gbn_pkg::t_cmd                 r_mem [gbn_pkg::QUEUE_DEPTH];
    logic [gbn_pkg::QPTR_W-1:0]    r_wr, r_rd;
    logic [gbn_pkg::QCNT_W-1:0]    r_count;

    assign o_full  = r_count == gbn_pkg::QCNT_W'(gbn_pkg::QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

[src/gbn_front.sv]
// Go-Back-N sender window: input side, accepts beats and classifies them.
// Depends on gbn_pkg; feeds gbn_fifo.
`timescale 1ns / 1ps
`default_nettype none

module gbn_front (
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  gbn_pkg::t_in                     i_in_data,
    input  wire logic [gbn_pkg::XFER_W-1:0]  i_xfer_bytes,
    input  wire logic                        i_q_full,
    output logic                             o_q_push,
    output gbn_pkg::t_cmd                    o_q_cmd
);

    assign o_in_stall = i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full;

    always_comb begin
        unique case (i_in_data.op)
            gbn_pkg::OP_START:   o_q_cmd.kind = gbn_pkg::CMD_START;
            gbn_pkg::OP_ACK:     o_q_cmd.kind = gbn_pkg::CMD_ACK;
            gbn_pkg::OP_TIMEOUT: o_q_cmd.kind = gbn_pkg::CMD_TIMEOUT;
            default:             o_q_cmd.kind = gbn_pkg::CMD_NOP;
        endcase
        // below the end of the object the offset fits the transfer width
        o_q_cmd.beyond = i_in_data.ack_offset >= gbn_pkg::ACK_W'(i_xfer_bytes);
        o_q_cmd.ack    = i_in_data.ack_offset[gbn_pkg::XFER_W-1:0];
    end

endmodule

`default_nettype wire

[src/gbn_back.sv]
// Go-Back-N sender window: window state, segment count division and burst release.
// Depends on gbn_pkg and gbn_div; drains gbn_fifo.
`timescale 1ns / 1ps
`default_nettype none

module gbn_back #(
    parameter int MAX_WINDOW  = 32,
    parameter int OFFSET_BITS = 24
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  gbn_pkg::t_cfg      i_cfg,
    input  wire logic          i_q_empty,
    output logic               o_q_pop,
    input  gbn_pkg::t_cmd      i_q_cmd,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output gbn_pkg::t_out      o_out_data
);

    localparam int CW    = (OFFSET_BITS > gbn_pkg::XFER_W) ? OFFSET_BITS : gbn_pkg::XFER_W;
    localparam int CNT_W = $clog2(MAX_WINDOW + 2);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DIVT  = 7'b0000010,
        S_DIVA  = 7'b0000100,
        S_ACK   = 7'b0001000,
        S_CHECK = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_EMPTY = 7'b1000000
    } t_state;

    t_state                         r_state, n_state;
    gbn_pkg::t_cmd                  r_cmd, n_cmd;
    logic [gbn_pkg::XFER_W-1:0]     r_total, n_total;
    logic [gbn_pkg::XFER_W-1:0]     r_seg, n_seg;
    logic [OFFSET_BITS-1:0]         r_oldest, n_oldest;
    logic [OFFSET_BITS-1:0]         r_next, n_next;
    logic [CNT_W-1:0]               r_cnt, n_cnt;
    logic [gbn_pkg::XFER_W-1:0]     r_prod, n_prod;
    logic                           r_out_valid, n_out_valid;
    gbn_pkg::t_out                  r_out, n_out;

    logic [gbn_pkg::SEG_W-1:0]                  eff_seg;
    logic [gbn_pkg::WIN_W-1:0]                  eff_win;
    logic [OFFSET_BITS:0]                       limit;
    logic                                       done;
    logic [CW-1:0]                              next_ext;
    logic [gbn_pkg::XFER_W+gbn_pkg::SEG_W-1:0]  prod_full;
    logic [OFFSET_BITS-1:0]                     next_inc;
    logic [CNT_W-1:0]                           cnt_inc;
    logic [OFFSET_BITS-1:0]                     seg_w;
    logic                                       seg_gt;
    logic [gbn_pkg::XFER_W-1:0]                 rem_bytes;
    logic [gbn_pkg::SEG_W-1:0]                  seg_len;
    logic                                       last;
    logic                                       out_space;
    logic                                       div_start;
    logic [gbn_pkg::XFER_W-1:0]                 div_num;
    gbn_pkg::t_div_rsp                          div_rsp;

    function automatic logic can_send(input logic [OFFSET_BITS-1:0]    nx,
                                      input logic [CNT_W-1:0]          cnt,
                                      input logic [OFFSET_BITS:0]      lim,
                                      input logic [gbn_pkg::XFER_W-1:0] tot);
        logic [CW-1:0] nx_e;
        logic [CW-1:0] tot_e;
        nx_e  = CW'(nx);
        tot_e = CW'(tot);
        return ({1'b0, nx} <= lim) && (nx_e < tot_e) && (cnt < CNT_W'(MAX_WINDOW + 1));
    endfunction

    gbn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (eff_seg),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        eff_seg = (i_cfg.seg_bytes == '0) ? gbn_pkg::SEG_W'(1) : i_cfg.seg_bytes;
        priority if (i_cfg.win_segs == '0) begin
            eff_win = gbn_pkg::WIN_W'(1);
        end else if (i_cfg.win_segs > gbn_pkg::WIN_W'(MAX_WINDOW)) begin
            eff_win = gbn_pkg::WIN_W'(MAX_WINDOW);
        end else begin
            eff_win = i_cfg.win_segs;
        end
    end

    assign limit     = {1'b0, r_oldest} + (OFFSET_BITS + 1)'(eff_win);
    assign done      = CW'(r_oldest) >= CW'(r_total);
    assign next_ext  = CW'(r_next);
    assign prod_full = next_ext[gbn_pkg::XFER_W-1:0] * eff_seg;
    assign next_inc  = r_next + 1'b1;
    assign cnt_inc   = r_cnt + 1'b1;
    assign seg_w     = OFFSET_BITS'(r_seg);
    assign seg_gt    = CW'(r_seg) > CW'(r_oldest);
    assign rem_bytes = i_cfg.xfer_bytes - r_prod;
    assign seg_len   = (rem_bytes < gbn_pkg::XFER_W'(eff_seg))
                       ? rem_bytes[gbn_pkg::SEG_W-1:0] : eff_seg;
    assign last      = !can_send(next_inc, cnt_inc, limit, r_total);
    assign out_space = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_total     = r_total;
        n_seg       = r_seg;
        n_oldest    = r_oldest;
        n_next      = r_next;
        n_cnt       = r_cnt;
        n_prod      = r_prod;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        o_q_pop     = 1'b0;
        div_start   = 1'b0;
        div_num     = i_cfg.xfer_bytes;

        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop   = 1'b1;
                    n_cmd     = i_q_cmd;
                    div_start = 1'b1;
                    n_state   = S_DIVT;
                end
            end
            S_DIVT: begin
                if (div_rsp.done) begin
                    // round the segment count up
                    n_total = div_rsp.quot + gbn_pkg::XFER_W'(div_rsp.rem_nz);
                    n_cnt   = '0;
                    unique case (r_cmd.kind)
                        gbn_pkg::CMD_START: begin
                            n_oldest = '0;
                            n_next   = '0;
                            n_state  = S_CHECK;
                        end
                        gbn_pkg::CMD_TIMEOUT: begin
                            n_next  = r_oldest;
                            n_state = S_CHECK;
                        end
                        gbn_pkg::CMD_ACK: begin
                            if (r_cmd.beyond) begin
                                n_seg   = n_total;
                                n_state = S_ACK;
                            end else begin
                                div_start = 1'b1;
                                div_num   = r_cmd.ack;
                                n_state   = S_DIVA;
                            end
                        end
                        default: n_state = S_EMPTY;
                    endcase
                end
            end
            S_DIVA: begin
                if (div_rsp.done) begin
                    n_seg   = div_rsp.quot;
                    n_state = S_ACK;
                end
            end
            S_ACK: begin
                if (seg_gt) begin
                    n_oldest = seg_w;
                    if (r_next < seg_w) begin
                        n_next = seg_w;
                    end
                    n_state = S_CHECK;
                end else begin
                    n_state = S_EMPTY;
                end
            end
            S_CHECK: begin
                if (can_send(r_next, r_cnt, limit, r_total)) begin
                    n_prod  = prod_full[gbn_pkg::XFER_W-1:0];
                    n_state = S_EMIT;
                end else begin
                    n_state = S_EMPTY;
                end
            end
            S_EMIT: begin
                if (out_space) begin
                    n_out_valid      = 1'b1;
                    n_out.seg_valid  = 1'b1;
                    n_out.seg_offset = r_prod;
                    n_out.seg_length = seg_len;
                    n_out.burst_last = last;
                    n_out.all_acked  = done;
                    n_next           = next_inc;
                    n_cnt            = cnt_inc;
                    n_state          = last ? S_IDLE : S_CHECK;
                end
            end
            S_EMPTY: begin
                if (out_space) begin
                    n_out_valid      = 1'b1;
                    n_out.seg_valid  = 1'b0;
                    n_out.seg_offset = '0;
                    n_out.seg_length = '0;
                    n_out.burst_last = 1'b1;
                    n_out.all_acked  = done;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_oldest    <= '0;
            r_next      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_oldest    <= n_oldest;
            r_next      <= n_next;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_cmd   <= n_cmd;
        r_total <= n_total;
        r_seg   <= n_seg;
        r_prod  <= n_prod;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIVT || r_state == S_DIVA))
        else $error("divider finished outside a division wait");

    a_pop_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state == S_DIVT))
        else $error("command popped without starting the count division");

    a_seg_in_object: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.seg_valid) |->
            (r_out.seg_length != '0 && r_out.seg_offset < i_cfg.xfer_bytes))
        else $error("released segment lies outside the object");

    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.seg_valid) |->
            (r_out.burst_last && r_out.seg_offset == '0 && r_out.seg_length == '0))
        else $error("empty result is malformed");

    a_burst_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_cnt < CNT_W'(MAX_WINDOW + 1)))
        else $error("burst longer than the window allows");

endmodule

`default_nettype wire
